// ----- hw/rtl/afu_pkg.sv -----
package afu_pkg;

  // activation_kind register codes; the unused code behaves as identity
  typedef enum logic [1:0] {
    KIND_SIGMOID  = 2'd0,
    KIND_RELU     = 2'd1,
    KIND_IDENTITY = 2'd2
  } kind_t;

  localparam int SERIES_TERMS = 24;

  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;
  localparam logic [15:0] ONE_Q12 = 16'd4096;
  // half of one Q4.12 step expressed in Q2.62
  localparam logic [63:0] HALF_STEP_Q62 = 64'h0002_0000_0000_0000;

  // series terms are divided by k one 16-bit digit per stage
  localparam int DIGIT_W    = 16;
  localparam int DIV_DIGITS = 4;
  localparam int REM_W      = 5;
  localparam int NUM_W      = REM_W + DIGIT_W;
  localparam int DIV_SHIFT  = 26;
  localparam int PROD_W     = 48;
  localparam int RECIP_W    = 27;
  localparam longint unsigned DIV_ONE = 64'd1 << DIV_SHIFT;

  // ceil(2^26 / k) for k = 1..24; exact quotients for numerators below 2^21
  localparam logic [RECIP_W-1:0] DIV_RECIP [SERIES_TERMS] = '{
    RECIP_W'((DIV_ONE + 0) / 1),    RECIP_W'((DIV_ONE + 1) / 2),
    RECIP_W'((DIV_ONE + 2) / 3),    RECIP_W'((DIV_ONE + 3) / 4),
    RECIP_W'((DIV_ONE + 4) / 5),    RECIP_W'((DIV_ONE + 5) / 6),
    RECIP_W'((DIV_ONE + 6) / 7),    RECIP_W'((DIV_ONE + 7) / 8),
    RECIP_W'((DIV_ONE + 8) / 9),    RECIP_W'((DIV_ONE + 9) / 10),
    RECIP_W'((DIV_ONE + 10) / 11),  RECIP_W'((DIV_ONE + 11) / 12),
    RECIP_W'((DIV_ONE + 12) / 13),  RECIP_W'((DIV_ONE + 13) / 14),
    RECIP_W'((DIV_ONE + 14) / 15),  RECIP_W'((DIV_ONE + 15) / 16),
    RECIP_W'((DIV_ONE + 16) / 17),  RECIP_W'((DIV_ONE + 17) / 18),
    RECIP_W'((DIV_ONE + 18) / 19),  RECIP_W'((DIV_ONE + 19) / 20),
    RECIP_W'((DIV_ONE + 20) / 21),  RECIP_W'((DIV_ONE + 21) / 22),
    RECIP_W'((DIV_ONE + 22) / 23),  RECIP_W'((DIV_ONE + 23) / 24)
  };

  // per-item data that rides alongside the sigmoid datapath
  typedef struct packed {
    logic        mode;
    logic        neg;
    logic        sig;
    logic        last;
    logic [15:0] alt;
  } side_t;

endpackage

// ----- hw/rtl/afu_if.sv -----
interface afu_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [15:0] value_in;
  logic               last_in;

  modport source (output valid, output mode, output value_in, output last_in, input ready);
  modport sink (input valid, input mode, input value_in, input last_in, output ready);
endinterface

interface afu_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value_out;
  logic               last_out;

  modport source (output valid, output value_out, output last_out, input ready);
  modport sink (input valid, input value_out, input last_out, output ready);
endinterface

// ----- hw/rtl/afu_mul62.sv -----
// (a * b) >> 62 truncated, over two stages: partial products, then sum
module afu_mul62 (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  afu_pkg::side_t  in_side,
  input  logic [63:0]     a,
  input  logic [63:0]     b,
  output logic            out_valid,
  output afu_pkg::side_t  out_side,
  output logic [63:0]     p
);

  logic           pp_valid;
  afu_pkg::side_t pp_side;
  logic [63:0]    ll;
  logic [63:0]    lh;
  logic [63:0]    hl;
  logic [63:0]    hh;
  logic [127:0]   full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      pp_valid  <= in_valid;
      out_valid <= pp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_side <= in_side;
      ll <= 64'(a[31:0]) * 64'(b[31:0]);
      lh <= 64'(a[31:0]) * 64'(b[63:32]);
      hl <= 64'(a[63:32]) * 64'(b[31:0]);
      hh <= 64'(a[63:32]) * 64'(b[63:32]);
    end
  end

  assign full = {hh, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= pp_side;
      p        <= full[125:62];
    end
  end

endmodule

// ----- hw/rtl/afu_exp_series.sv -----
// exp(-mag/32768) in Q2.62 by a 25-term alternating series.
// Each term: one multiply stage, one shift stage, four divide-by-k digit stages.
module afu_exp_series (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  afu_pkg::side_t  in_side,
  input  logic [15:0]     mag,
  output logic            out_valid,
  output afu_pkg::side_t  out_side,
  output logic [63:0]     sum
);

  localparam int Terms  = afu_pkg::SERIES_TERMS;
  localparam int Digits = afu_pkg::DIV_DIGITS;
  localparam int DigW   = afu_pkg::DIGIT_W;
  localparam bit LastSub = (Terms % 2) == 1;

  logic           ch_valid [Terms+1];
  afu_pkg::side_t ch_side  [Terms+1];
  logic [15:0]    ch_mag   [Terms+1];
  logic [63:0]    ch_sum   [Terms+1];
  logic [63:0]    ch_term  [Terms+1];

  assign ch_valid[0] = in_valid;
  assign ch_side[0]  = in_side;
  assign ch_mag[0]   = mag;
  assign ch_sum[0]   = '0;
  assign ch_term[0]  = afu_pkg::ONE_Q62;

  for (genvar t = 0; t < Terms; t++) begin : g_term
    localparam logic [afu_pkg::REM_W-1:0]   K     = afu_pkg::REM_W'(t + 1);
    localparam logic [afu_pkg::RECIP_W-1:0] RECIP = afu_pkg::DIV_RECIP[t];
    // the term arriving here has index t; odd indexes are subtracted
    localparam bit SUB = (t % 2) == 1;

    logic           m_valid;
    afu_pkg::side_t m_side;
    logic [15:0]    m_mag;
    logic [63:0]    m_sum;
    logic [47:0]    m_lo;
    logic [46:0]    m_hi;

    always_ff @(posedge clk) begin
      if (rst) begin
        m_valid <= 1'b0;
      end else if (en) begin
        m_valid <= ch_valid[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_side <= ch_side[t];
        m_mag  <= ch_mag[t];
        m_sum  <= SUB ? ch_sum[t] - ch_term[t] : ch_sum[t] + ch_term[t];
        m_lo   <= 48'(ch_term[t][31:0]) * 48'(ch_mag[t]);
        m_hi   <= 47'(ch_term[t][62:32]) * 47'(ch_mag[t]);
      end
    end

    logic                        d_valid [Digits+1];
    afu_pkg::side_t              d_side  [Digits+1];
    logic [15:0]                 d_mag   [Digits+1];
    logic [63:0]                 d_sum   [Digits+1];
    logic [63:0]                 d_work  [Digits+1];
    logic [afu_pkg::REM_W-1:0]   d_rem   [Digits+1];

    // term * u in Q2.62 equals term * mag >> 15
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[0] <= 1'b0;
      end else if (en) begin
        d_valid[0] <= m_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_side[0] <= m_side;
        d_mag[0]  <= m_mag;
        d_sum[0]  <= m_sum;
        d_work[0] <= 64'(({m_hi, 32'd0} + 79'(m_lo)) >> 15);
        d_rem[0]  <= '0;
      end
    end

    for (genvar j = 0; j < Digits; j++) begin : g_digit
      localparam int Top = 63 - DigW * j;

      logic [afu_pkg::NUM_W-1:0]  num;
      logic [afu_pkg::PROD_W-1:0] prod;
      logic [DigW-1:0]            qd;
      logic [afu_pkg::NUM_W-1:0]  back;
      logic [63:0]                work_next;

      assign num  = {d_rem[j], d_work[j][Top -: DigW]};
      assign prod = afu_pkg::PROD_W'(num) * afu_pkg::PROD_W'(RECIP);
      assign qd   = prod[afu_pkg::DIV_SHIFT +: DigW];
      assign back = num - afu_pkg::NUM_W'(qd) * afu_pkg::NUM_W'(K);

      always_comb begin
        work_next = d_work[j];
        work_next[Top -: DigW] = qd;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          d_valid[j+1] <= 1'b0;
        end else if (en) begin
          d_valid[j+1] <= d_valid[j];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          d_side[j+1] <= d_side[j];
          d_mag[j+1]  <= d_mag[j];
          d_sum[j+1]  <= d_sum[j];
          d_work[j+1] <= work_next;
          d_rem[j+1]  <= back[afu_pkg::REM_W-1:0];
        end
      end
    end

    assign ch_valid[t+1] = d_valid[Digits];
    assign ch_side[t+1]  = d_side[Digits];
    assign ch_mag[t+1]   = d_mag[Digits];
    assign ch_sum[t+1]   = d_sum[Digits];
    assign ch_term[t+1]  = d_work[Digits];
  end

  // fold in the last term
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ch_valid[Terms];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= ch_side[Terms];
      sum      <= LastSub ? ch_sum[Terms] - ch_term[Terms] : ch_sum[Terms] + ch_term[Terms];
    end
  end

endmodule

// ----- hw/rtl/afu_recip.sv -----
// floor(2^124 / (1.0 + e)) by restoring division, one quotient bit per stage.
// The first 62 steps only shift (divisor lies in (2^62, 2^63]), so the
// pipeline starts from remainder 2^62 and forms the 62 remaining bits.
module afu_recip (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  afu_pkg::side_t  in_side,
  input  logic [63:0]     e,
  output logic            out_valid,
  output afu_pkg::side_t  out_side,
  output logic [61:0]     f
);

  localparam int Bits = 62;

  logic           s_valid [Bits+1];
  afu_pkg::side_t s_side  [Bits+1];
  logic [63:0]    s_div   [Bits+1];
  logic [63:0]    s_rem   [Bits+1];
  logic [61:0]    s_quo   [Bits+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (en) begin
      s_valid[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_side[0] <= in_side;
      s_div[0]  <= afu_pkg::ONE_Q62 + e;
      s_rem[0]  <= afu_pkg::ONE_Q62;
      s_quo[0]  <= '0;
    end
  end

  for (genvar i = 0; i < Bits; i++) begin : g_bit
    logic [63:0] shifted;
    logic        ge;

    assign shifted = {s_rem[i][62:0], 1'b0};
    assign ge      = shifted >= s_div[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[i+1] <= 1'b0;
      end else if (en) begin
        s_valid[i+1] <= s_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_side[i+1] <= s_side[i];
        s_div[i+1]  <= s_div[i];
        s_rem[i+1]  <= ge ? shifted - s_div[i] : shifted;
        s_quo[i+1]  <= {s_quo[i][60:0], ge};
      end
    end
  end

  assign out_valid = s_valid[Bits];
  assign out_side  = s_side[Bits];
  assign f         = s_quo[Bits];

endmodule

// ----- hw/rtl/activation_function_unit.sv -----
// Elementwise activation over signed Q4.12 values: sigmoid, ReLU or identity
// (activation_kind), the function or its derivative per item (mode), results
// rounded to nearest Q4.12 and the last marker carried along. One item is
// accepted every clock while the pipeline is not held; every item, of any kind,
// passes in order through the sigmoid datapath: 145 stages of exp series
// (six per term), three two-stage squarings, the 63-stage bit-per-stage
// reciprocal, a final multiply and rounding. A two-entry output buffer lets
// the pipeline keep moving after the sink stalls, until the skid entry
// fills; then the whole pipeline holds. Write activation_kind only while no
// item is in flight.
module activation_function_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  afu_item_if.sink     item,
  afu_result_if.source result
);

  logic [1:0] kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= afu_pkg::KIND_SIGMOID;
    end else if (cfg_wr_en) begin
      kind <= cfg_wr_data;
    end
  end

  // pipeline advance; held while the skid register is occupied
  logic en;
  logic skid_valid;

  assign en         = !skid_valid;
  assign item.ready = en;

  // entry stage
  logic           pos;
  logic [15:0]    in_mag;
  logic [15:0]    in_alt;
  afu_pkg::side_t in_side;

  assign pos    = item.value_in > 16'sd0;
  assign in_mag = item.value_in[15] ? 16'(-item.value_in) : item.value_in;

  always_comb begin
    case (kind)
      afu_pkg::KIND_SIGMOID: in_alt = '0;
      afu_pkg::KIND_RELU: begin
        if (item.mode) begin
          in_alt = pos ? afu_pkg::ONE_Q12 : 16'd0;
        end else begin
          in_alt = pos ? item.value_in : 16'd0;
        end
      end
      default: in_alt = item.mode ? afu_pkg::ONE_Q12 : item.value_in;
    endcase
  end

  always_comb begin
    in_side.mode = item.mode;
    in_side.neg  = item.value_in[15];
    in_side.sig  = kind == afu_pkg::KIND_SIGMOID;
    in_side.last = item.last_in;
    in_side.alt  = in_alt;
  end

  logic           ent_valid;
  afu_pkg::side_t ent_side;
  logic [15:0]    ent_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
    end else if (en) begin
      ent_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_side <= in_side;
      ent_mag  <= in_mag;
    end
  end

  // exp(-|x|/8) then three squarings
  logic           ser_valid;
  afu_pkg::side_t ser_side;
  logic [63:0]    ser_sum;

  afu_exp_series u_series (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ent_valid),
    .in_side   (ent_side),
    .mag       (ent_mag),
    .out_valid (ser_valid),
    .out_side  (ser_side),
    .sum       (ser_sum)
  );

  logic           sq_valid [4];
  afu_pkg::side_t sq_side  [4];
  logic [63:0]    sq_val   [4];

  assign sq_valid[0] = ser_valid;
  assign sq_side[0]  = ser_side;
  assign sq_val[0]   = ser_sum;

  for (genvar s = 0; s < 3; s++) begin : g_square
    afu_mul62 u_sq (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[s]),
      .in_side   (sq_side[s]),
      .a         (sq_val[s]),
      .b         (sq_val[s]),
      .out_valid (sq_valid[s+1]),
      .out_side  (sq_side[s+1]),
      .p         (sq_val[s+1])
    );
  end

  // f = 1 / (1 + e)
  logic           rc_valid;
  afu_pkg::side_t rc_side;
  logic [61:0]    rc_f;

  afu_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid[3]),
    .in_side   (sq_side[3]),
    .e         (sq_val[3]),
    .out_valid (rc_valid),
    .out_side  (rc_side),
    .f         (rc_f)
  );

  // derivative: f * (1 - f); value: f or 1 - f, times 1.0
  logic           sel_valid;
  afu_pkg::side_t sel_side;
  logic [63:0]    sel_a;
  logic [63:0]    sel_b;
  logic [63:0]    rc_f64;
  logic [63:0]    rc_inv;

  assign rc_f64 = {2'b00, rc_f};
  assign rc_inv = afu_pkg::ONE_Q62 - rc_f64;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (en) begin
      sel_valid <= rc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_side <= rc_side;
      if (rc_side.mode) begin
        sel_a <= rc_f64;
        sel_b <= rc_inv;
      end else begin
        sel_a <= rc_side.neg ? rc_inv : rc_f64;
        sel_b <= afu_pkg::ONE_Q62;
      end
    end
  end

  logic           fm_valid;
  afu_pkg::side_t fm_side;
  logic [63:0]    fm_p;

  afu_mul62 u_final (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sel_valid),
    .in_side   (sel_side),
    .a         (sel_a),
    .b         (sel_b),
    .out_valid (fm_valid),
    .out_side  (fm_side),
    .p         (fm_p)
  );

  // round to Q4.12
  logic        rnd_valid;
  logic [15:0] rnd_value;
  logic        rnd_last;
  logic [63:0] rounded;

  assign rounded = fm_p + afu_pkg::HALF_STEP_Q62;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= fm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_value <= fm_side.sig ? {2'b00, rounded[63:50]} : fm_side.alt;
      rnd_last  <= fm_side.last;
    end
  end

  // output register plus skid
  logic        out_valid;
  logic [15:0] out_value;
  logic        out_last;
  logic [15:0] skid_value;
  logic        skid_last;
  logic        out_free;
  logic        emit;

  assign out_free = !out_valid || result.ready;
  assign emit     = en && rnd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_value <= skid_value;
        out_last  <= skid_last;
      end else begin
        out_value <= rnd_value;
        out_last  <= rnd_last;
      end
    end else if (emit) begin
      skid_value <= rnd_value;
      skid_last  <= rnd_last;
    end
  end

  assign result.valid     = out_valid;
  assign result.value_out = out_value;
  assign result.last_out  = out_last;

endmodule
